[src/ocr_pkg.sv]
// Shared types, constants and tables for the orbit camera rotate block.
// No dependencies; imported by every module of the block except ocr_mul.
package ocr_pkg;

   // Field widths and command codes
   localparam int CMD_W = 2;
   localparam int ANGLE_W = 15;
   localparam int COORD_WIDTH_DEF = 24;
   localparam logic [CMD_W-1:0] CMD_LOAD = 2'd0;
   localparam logic [CMD_W-1:0] CMD_LEFT = 2'd1;
   localparam logic [CMD_W-1:0] CMD_UP = 2'd2;

   // Unit vector / sine / cosine format: signed Q2.28
   localparam int UNIT_SHIFT = 28;
   localparam int UNIT_W = 30;

   // CORDIC
   localparam int CORDIC_STEPS = 18;
   localparam int CORDIC_GAIN = 163008219;
   localparam int HALF_TURN = 180 * 64;
   localparam int QUARTER_TURN = 90 * 64;
   localparam int FULL_TURN = 360 * 64;

   // Root and divide recurrences
   localparam int ROOT_STEPS = 32;
   localparam int QUO_STEPS = 30;

   typedef enum logic {
      RD_SQRT = 1'b0,
      RD_DIV  = 1'b1
   } rd_mode_type;

   typedef struct packed {
      logic        start;
      rd_mode_type mode;
   } rd_ctrl_type;

   // atan(2^-i) in Q16 degrees
   function automatic logic [21:0] atan_q16(input logic [4:0] idx);
      logic [21:0] val;
      case (idx)
         5'd0: val = 22'd2949120;
         5'd1: val = 22'd1740967;
         5'd2: val = 22'd919879;
         5'd3: val = 22'd466945;
         5'd4: val = 22'd234379;
         5'd5: val = 22'd117304;
         5'd6: val = 22'd58666;
         5'd7: val = 22'd29335;
         5'd8: val = 22'd14668;
         5'd9: val = 22'd7334;
         5'd10: val = 22'd3667;
         5'd11: val = 22'd1833;
         5'd12: val = 22'd917;
         5'd13: val = 22'd458;
         5'd14: val = 22'd229;
         5'd15: val = 22'd115;
         5'd16: val = 22'd57;
         5'd17: val = 22'd29;
         default: val = 22'd0;
      endcase
      return val;
   endfunction

endpackage

[src/ocr_mul.sv]
// Shared signed multiplier with a registered product.
// No package dependencies; used by the top-level sequencer.
module ocr_mul #(
   parameter int MW = 32
) (
   input  logic                   clock,
   input  logic signed [MW-1:0]   op_a,
   input  logic signed [MW-1:0]   op_b,
   output logic signed [2*MW-1:0] prod_ff
);

   // one product per cycle, product registered
   always_ff @(posedge clock) begin
      prod_ff <= op_a * op_b;
   end

endmodule

[src/ocr_cordic.sv]
// Iterative rotation-mode CORDIC for sine and cosine of an angle in 1/64 degree.
// Depends on ocr_pkg (CORDIC constants, atan table).
module ocr_cordic (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic signed [15:0]            angle,
   output logic                          busy,
   output logic signed [ocr_pkg::UNIT_W-1:0] sin_q,
   output logic signed [ocr_pkg::UNIT_W-1:0] cos_q
);
   import ocr_pkg::*;

   localparam int XW = 32;
   localparam int ZW = 28;
   localparam logic signed [16:0] HALF_S = 17'(HALF_TURN);
   localparam logic signed [16:0] QUART_S = 17'(QUARTER_TURN);
   localparam logic signed [16:0] FULL_S = 17'(FULL_TURN);
   localparam logic signed [XW:0] ONE_S = (XW+1)'(1 << UNIT_SHIFT);

   logic run_ff, run_in;
   logic flip_ff, flip_in;
   logic [4:0] i_ff, i_in;
   logic signed [XW-1:0] x_ff, x_in, y_ff, y_in;
   logic signed [ZW-1:0] z_ff, z_in;
   logic signed [16:0] a_ext, a_wrap, a_fold;
   logic signed [XW-1:0] dx, dy;
   logic signed [ZW-1:0] step_atan;
   logic signed [XW:0] xf, yf;

   // range reduction into [-90, 90] degrees
   always_comb begin
      a_ext = 17'(angle);
      if (a_ext > HALF_S) begin
         a_wrap = a_ext - FULL_S;
      end else if (a_ext < -HALF_S) begin
         a_wrap = a_ext + FULL_S;
      end else begin
         a_wrap = a_ext;
      end
      flip_in = flip_ff;
      if (a_wrap > QUART_S) begin
         a_fold = a_wrap - HALF_S;
      end else if (a_wrap < -QUART_S) begin
         a_fold = a_wrap + HALF_S;
      end else begin
         a_fold = a_wrap;
      end
      if (start) flip_in = (a_wrap > QUART_S) || (a_wrap < -QUART_S);
   end

   // one micro-rotation per cycle
   always_comb begin
      dx = y_ff >>> i_ff;
      dy = x_ff >>> i_ff;
      step_atan = ZW'(atan_q16(i_ff));
      run_in = run_ff;
      i_in = i_ff;
      x_in = x_ff;
      y_in = y_ff;
      z_in = z_ff;
      if (start) begin
         run_in = 1'b1;
         i_in = '0;
         x_in = XW'(CORDIC_GAIN);
         y_in = '0;
         z_in = ZW'(a_fold) <<< 10;
      end else if (run_ff) begin
         if (z_ff >= 0) begin
            x_in = x_ff - dx;
            y_in = y_ff + dy;
            z_in = z_ff - step_atan;
         end else begin
            x_in = x_ff + dx;
            y_in = y_ff - dy;
            z_in = z_ff + step_atan;
         end
         i_in = i_ff + 5'd1;
         if (i_ff == 5'(CORDIC_STEPS - 1)) begin
            run_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
      end else begin
         run_ff <= run_in;
      end
      flip_ff <= flip_in;
      i_ff <= i_in;
      x_ff <= x_in;
      y_ff <= y_in;
      z_ff <= z_in;
   end

   // undo the fold and clamp to one
   always_comb begin
      xf = flip_ff ? -(XW+1)'(x_ff) : (XW+1)'(x_ff);
      yf = flip_ff ? -(XW+1)'(y_ff) : (XW+1)'(y_ff);
      if (xf > ONE_S) xf = ONE_S;
      else if (xf < -ONE_S) xf = -ONE_S;
      if (yf > ONE_S) yf = ONE_S;
      else if (yf < -ONE_S) yf = -ONE_S;
      cos_q = UNIT_W'(xf);
      sin_q = UNIT_W'(yf);
   end

   assign busy = run_ff;

endmodule

[src/ocr_rootdiv.sv]
// Shared subtract-and-compare unit: 64-bit integer square root and the
// unit-axis division by that root, one digit per cycle. Depends on ocr_pkg.
module ocr_rootdiv (
   input  logic                        clock,
   input  logic                        reset,
   input  ocr_pkg::rd_ctrl_type        ctrl,
   input  logic [63:0]                 radicand,
   input  logic [ocr_pkg::UNIT_W-1:0]  dvd_mag,
   output logic                        busy,
   output logic [ocr_pkg::QUO_STEPS-1:0] quotient
);
   import ocr_pkg::*;

   logic run_ff, run_in;
   rd_mode_type mode_ff, mode_in;
   logic [5:0] cnt_ff, cnt_in;
   logic [63:0] v_ff, v_in, res_ff, res_in, bit_ff, bit_in;
   logic [31:0] rem_ff, rem_in, divisor;
   logic [UNIT_W-1:0] num_ff, num_in;
   logic [QUO_STEPS-1:0] q_ff, q_in;
   logic [64:0] lhs, rhs, diff;
   logic ge, last;

   // shared compare
   always_comb begin
      divisor = (res_ff[31:0] == '0) ? 32'd1 : res_ff[31:0];
      if (mode_ff == RD_SQRT) begin
         lhs = {1'b0, v_ff};
         rhs = {1'b0, res_ff | bit_ff};
      end else begin
         lhs = {32'd0, rem_ff, num_ff[UNIT_W-1]};
         rhs = {33'd0, divisor};
      end
      diff = lhs - rhs;
      ge = !diff[64];
      last = (mode_ff == RD_SQRT) ? (cnt_ff == 6'(ROOT_STEPS - 1))
                                  : (cnt_ff == 6'(QUO_STEPS - 1));
   end

   always_comb begin
      run_in = run_ff;
      mode_in = mode_ff;
      cnt_in = cnt_ff;
      v_in = v_ff;
      res_in = res_ff;
      bit_in = bit_ff;
      rem_in = rem_ff;
      num_in = num_ff;
      q_in = q_ff;
      if (ctrl.start) begin
         run_in = 1'b1;
         mode_in = ctrl.mode;
         cnt_in = '0;
         if (ctrl.mode == RD_SQRT) begin
            v_in = radicand;
            res_in = '0;
            bit_in = 64'h4000_0000_0000_0000;
         end else begin
            // dividend is |b| * 2^28; the top bits start the remainder
            rem_in = 32'(dvd_mag[UNIT_W-1:UNIT_W-UNIT_SHIFT]);
            num_in = {dvd_mag[UNIT_W-UNIT_SHIFT-1:0], UNIT_SHIFT'(0)};
            q_in = '0;
         end
      end else if (run_ff) begin
         cnt_in = cnt_ff + 6'd1;
         if (last) run_in = 1'b0;
         if (mode_ff == RD_SQRT) begin
            if (ge) begin
               v_in = diff[63:0];
               res_in = (res_ff >> 1) + bit_ff;
            end else begin
               res_in = res_ff >> 1;
            end
            bit_in = bit_ff >> 2;
         end else begin
            rem_in = ge ? diff[31:0] : lhs[31:0];
            num_in = num_ff << 1;
            q_in = {q_ff[QUO_STEPS-2:0], ge};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
         mode_ff <= RD_SQRT;
      end else begin
         run_ff <= run_in;
         mode_ff <= mode_in;
      end
      cnt_ff <= cnt_in;
      v_ff <= v_in;
      res_ff <= res_in;
      bit_ff <= bit_in;
      rem_ff <= rem_in;
      num_ff <= num_in;
      q_ff <= q_in;
   end

   assign busy = run_ff;
   assign quotient = q_ff;

endmodule

[src/orbit_camera_rotate_core.sv]
// Orbit camera rotate core: sequencer, vector store and rotation datapath.
// Depends on ocr_pkg, ocr_mul, ocr_cordic and ocr_rootdiv.
//
//  channel | dir | handshake            | payload
//  --------+-----+----------------------+---------------------------------------
//  req     | in  | req_tvalid/tready    | tuser: cmd; tdata: angle, load eye, up
//  rsp     | out | rsp_tvalid/tready    | tdata: eye, up; tuser: degenerate
//
//  A load or unused command goes straight from idle to the done state, which
//  registers the result. An orbit's result time is set by one shared
//  multiplier (19 products per rotated vector), the leading-bit shift loop,
//  the 32-step root and three 30-step divides in the shared unit.
//  One word in flight; req_tready is high only when the sequencer is idle,
//  even while a finished result waits on rsp. Synchronous reset clears the
//  vectors to zero and the control state.
module orbit_camera_rotate_core #(
   parameter int COORD_WIDTH = ocr_pkg::COORD_WIDTH_DEF,
   parameter int IN_W  = ((ocr_pkg::ANGLE_W + 6 * COORD_WIDTH + 7) / 8) * 8,
   parameter int OUT_W = ((6 * COORD_WIDTH + 7) / 8) * 8
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   // angle, load_eye_x, load_eye_y, load_eye_z, load_up_x, load_up_y, load_up_z
   input  logic [IN_W-1:0]           req_tdata,
   // cmd
   input  logic [ocr_pkg::CMD_W-1:0] req_tuser,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   // eye_out_x, eye_out_y, eye_out_z, up_out_x, up_out_y, up_out_z
   output logic [OUT_W-1:0]          rsp_tdata,
   // degenerate
   output logic                      rsp_tuser
);
   import ocr_pkg::*;

   localparam int CW = COORD_WIDTH;
   localparam int MW = (CW + 4 > 32) ? CW + 4 : 32;
   localparam int PW = 2 * MW;
   localparam int AW = PW + 2;
   localparam logic signed [AW-1:0] RND_HALF = AW'(1 << (UNIT_SHIFT - 1));
   localparam logic signed [AW-1:0] SAT_HI = AW'(64'h7FFF_FFFF_FFFF_FFFF);
   localparam logic signed [AW-1:0] C_HI = AW'((64'd1 << (CW - 1)) - 64'd1);
   localparam logic signed [AW-1:0] C_LO = -C_HI - AW'(1);
   localparam logic signed [MW-1:0] UNIT_ONE = MW'(1 << UNIT_SHIFT);
   localparam logic [QUO_STEPS-1:0] Q_ONE = QUO_STEPS'(1 << UNIT_SHIFT);

   typedef enum logic [8:0] {
      ST_IDLE   = 9'b000000001,
      ST_CROSS  = 9'b000000010,
      ST_NSCAN  = 9'b000000100,
      ST_NSHIFT = 9'b000001000,
      ST_SQUARE = 9'b000010000,
      ST_ROOT   = 9'b000100000,
      ST_DIV    = 9'b001000000,
      ST_ROT    = 9'b010000000,
      ST_DONE   = 9'b100000000
   } state_type;

   function automatic logic signed [AW-1:0] rnd_f(input logic signed [AW-1:0] v);
      logic signed [AW-1:0] s;
      s = v + RND_HALF;
      return s >>> UNIT_SHIFT;
   endfunction

   state_type state_ff, state_in;
   logic [4:0] cnt_ff, cnt_in;
   logic [CMD_W-1:0] cmd_ff, cmd_in;
   logic pass_ff, pass_in;
   logic degen_ff, degen_in;
   logic signed [CW-1:0] eye_ff [3];
   logic signed [CW-1:0] eye_in [3];
   logic signed [CW-1:0] up_ff [3];
   logic signed [CW-1:0] up_in [3];
   logic signed [63:0] ax_ff [3];
   logic signed [63:0] ax_in [3];
   logic [63:0] abs_w [3];
   logic [63:0] m_ff, m_in, mmax, sum_ff, sum_in;
   logic signed [UNIT_W-1:0] u_ff [3];
   logic signed [UNIT_W-1:0] u_in [3];
   logic signed [AW-1:0] acc_ff, acc_in;
   logic signed [MW-1:0] d_ff, d_in, t_ff, t_in;
   logic signed [MW-1:0] w_ff [3];
   logic signed [MW-1:0] w_in [3];
   logic signed [AW-1:0] o_ff [3];
   logic signed [AW-1:0] o_in [3];
   logic rsp_tvalid_ff, rsp_tvalid_in;
   logic [OUT_W-1:0] rsp_tdata_ff, rsp_tdata_in;
   logic rsp_tuser_ff, rsp_tuser_in;

   logic signed [MW-1:0] op_a, op_b;
   logic signed [PW-1:0] prod;
   logic signed [AW-1:0] pa, diff, rv;
   logic signed [CW-1:0] vsel [3];
   logic signed [CW-1:0] sat_o [3];
   logic [4:0] j;

   rd_ctrl_type rd_ctrl;
   logic [1:0] rd_idx;
   logic rd_busy;
   logic [QUO_STEPS-1:0] quo, quo_c;
   logic [63:0] radicand;
   logic cord_start, cord_busy;
   logic signed [15:0] angle16, cord_angle;
   logic signed [UNIT_W-1:0] sin_q, cos_q;
   logic signed [UNIT_W-1:0] u_new;

   ocr_mul #(.MW(MW)) u_mul (
      .clock(clock), .op_a(op_a), .op_b(op_b), .prod_ff(prod)
   );

   ocr_cordic u_cordic (
      .clock(clock), .reset(reset), .start(cord_start), .angle(cord_angle),
      .busy(cord_busy), .sin_q(sin_q), .cos_q(cos_q)
   );

   ocr_rootdiv u_rootdiv (
      .clock(clock), .reset(reset), .ctrl(rd_ctrl), .radicand(radicand),
      .dvd_mag(abs_w[rd_idx][UNIT_W-1:0]), .busy(rd_busy), .quotient(quo)
   );

   // axis magnitudes and largest magnitude
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         abs_w[i] = ax_ff[i][63] ? 64'(-ax_ff[i]) : 64'(ax_ff[i]);
      end
      mmax = abs_w[0];
      if (abs_w[1] > mmax) mmax = abs_w[1];
      if (abs_w[2] > mmax) mmax = abs_w[2];
   end

   // vector under rotation and saturated results
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         vsel[i] = pass_ff ? up_ff[i] : eye_ff[i];
         if (o_ff[i] > C_HI) sat_o[i] = CW'(C_HI);
         else if (o_ff[i] < C_LO) sat_o[i] = CW'(C_LO);
         else sat_o[i] = CW'(o_ff[i]);
      end
   end

   assign angle16 = 16'(signed'(req_tdata[ANGLE_W-1:0]));
   assign cord_angle = (req_tuser == CMD_UP) ? -angle16 : angle16;
   assign pa = AW'(prod);
   assign j = cnt_ff - 5'd1;
   assign req_tready = (state_ff == ST_IDLE);
   assign quo_c = (quo > Q_ONE) ? Q_ONE : quo;

   // sequencer
   always_comb begin
      state_in = state_ff;
      cnt_in = cnt_ff;
      cmd_in = cmd_ff;
      pass_in = pass_ff;
      degen_in = degen_ff;
      eye_in = eye_ff;
      up_in = up_ff;
      ax_in = ax_ff;
      m_in = m_ff;
      sum_in = sum_ff;
      u_in = u_ff;
      acc_in = acc_ff;
      d_in = d_ff;
      t_in = t_ff;
      w_in = w_ff;
      o_in = o_ff;
      op_a = '0;
      op_b = '0;
      diff = '0;
      rv = '0;
      u_new = '0;
      rd_ctrl = '{start: 1'b0, mode: RD_SQRT};
      rd_idx = 2'd0;
      radicand = sum_ff;
      cord_start = 1'b0;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      rsp_tdata_in = rsp_tdata_ff;
      rsp_tuser_in = rsp_tuser_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd_in = req_tuser;
               cnt_in = '0;
               pass_in = 1'b0;
               degen_in = 1'b0;
               case (req_tuser)
                  CMD_LOAD: begin
                     for (int i = 0; i < 3; i++) begin
                        eye_in[i] = signed'(req_tdata[ANGLE_W + i*CW +: CW]);
                        up_in[i] = signed'(req_tdata[ANGLE_W + (i+3)*CW +: CW]);
                     end
                     state_in = ST_DONE;
                  end
                  CMD_LEFT: begin
                     for (int i = 0; i < 3; i++) ax_in[i] = 64'(up_ff[i]);
                     cord_start = 1'b1;
                     state_in = ST_NSCAN;
                  end
                  CMD_UP: begin
                     cord_start = 1'b1;
                     state_in = ST_CROSS;
                  end
                  default: state_in = ST_DONE;
               endcase
            end
         end

         // cross(up, eye): six products, paired differences saturated
         ST_CROSS: begin
            case (cnt_ff)
               5'd0: begin op_a = MW'(up_ff[1]); op_b = MW'(eye_ff[2]); end
               5'd1: begin op_a = MW'(up_ff[2]); op_b = MW'(eye_ff[1]); end
               5'd2: begin op_a = MW'(up_ff[2]); op_b = MW'(eye_ff[0]); end
               5'd3: begin op_a = MW'(up_ff[0]); op_b = MW'(eye_ff[2]); end
               5'd4: begin op_a = MW'(up_ff[0]); op_b = MW'(eye_ff[1]); end
               5'd5: begin op_a = MW'(up_ff[1]); op_b = MW'(eye_ff[0]); end
               default: begin op_a = '0; op_b = '0; end
            endcase
            if (cnt_ff != 5'd0) begin
               if (!j[0]) begin
                  acc_in = pa;
               end else begin
                  diff = acc_ff - pa;
                  if (diff > SAT_HI) diff = SAT_HI;
                  else if (diff < -SAT_HI) diff = -SAT_HI;
                  case (j)
                     5'd1: ax_in[0] = 64'(diff);
                     5'd3: ax_in[1] = 64'(diff);
                     default: ax_in[2] = 64'(diff);
                  endcase
               end
            end
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'd6) state_in = ST_NSCAN;
         end

         ST_NSCAN: begin
            if (mmax == '0) begin
               degen_in = 1'b1;
               state_in = ST_DONE;
            end else begin
               m_in = mmax;
               state_in = ST_NSHIFT;
            end
         end

         // bring the largest magnitude into [2^29, 2^30)
         ST_NSHIFT: begin
            if (m_ff[63:29] == '0) begin
               m_in = m_ff << 1;
               for (int i = 0; i < 3; i++) ax_in[i] = ax_ff[i] <<< 1;
            end else if (|m_ff[63:30]) begin
               m_in = m_ff >> 1;
               for (int i = 0; i < 3; i++) ax_in[i] = ax_ff[i] >>> 1;
            end else begin
               cnt_in = '0;
               sum_in = '0;
               state_in = ST_SQUARE;
            end
         end

         // sum of squares, then start the root
         ST_SQUARE: begin
            case (cnt_ff)
               5'd0: begin
                  op_a = signed'(ax_ff[0][MW-1:0]);
                  op_b = signed'(ax_ff[0][MW-1:0]);
               end
               5'd1: begin
                  op_a = signed'(ax_ff[1][MW-1:0]);
                  op_b = signed'(ax_ff[1][MW-1:0]);
               end
               5'd2: begin
                  op_a = signed'(ax_ff[2][MW-1:0]);
                  op_b = signed'(ax_ff[2][MW-1:0]);
               end
               default: begin op_a = '0; op_b = '0; end
            endcase
            if (cnt_ff != 5'd0) sum_in = sum_ff + prod[63:0];
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'd3) begin
               // root of the full sum, last square included
               radicand = sum_in;
               rd_ctrl = '{start: 1'b1, mode: RD_SQRT};
               state_in = ST_ROOT;
            end
         end

         ST_ROOT: begin
            if (!rd_busy) begin
               rd_ctrl = '{start: 1'b1, mode: RD_DIV};
               rd_idx = 2'd0;
               cnt_in = '0;
               state_in = ST_DIV;
            end
         end

         // unit components, sign applied after the clamp
         ST_DIV: begin
            if (!rd_busy) begin
               u_new = UNIT_W'(quo_c);
               case (cnt_ff[1:0])
                  2'd0: u_in[0] = ax_ff[0][63] ? -u_new : u_new;
                  2'd1: u_in[1] = ax_ff[1][63] ? -u_new : u_new;
                  default: u_in[2] = ax_ff[2][63] ? -u_new : u_new;
               endcase
               if (cnt_ff == 5'd2) begin
                  cnt_in = '0;
                  state_in = ST_ROT;
               end else begin
                  cnt_in = cnt_ff + 5'd1;
                  rd_idx = cnt_ff[1:0] + 2'd1;
                  rd_ctrl = '{start: 1'b1, mode: RD_DIV};
               end
            end
         end

         // Rodrigues rotation of one vector, 19 products
         ST_ROT: begin
            if (!cord_busy) begin
               case (cnt_ff)
                  5'd0: begin op_a = MW'(u_ff[0]); op_b = MW'(vsel[0]); end
                  5'd1: begin op_a = MW'(u_ff[1]); op_b = MW'(vsel[1]); end
                  5'd2: begin op_a = MW'(u_ff[2]); op_b = MW'(vsel[2]); end
                  5'd3: begin op_a = MW'(u_ff[1]); op_b = MW'(vsel[2]); end
                  5'd4: begin op_a = MW'(u_ff[2]); op_b = MW'(vsel[1]); end
                  5'd5: begin op_a = MW'(u_ff[2]); op_b = MW'(vsel[0]); end
                  5'd6: begin op_a = MW'(u_ff[0]); op_b = MW'(vsel[2]); end
                  5'd7: begin op_a = MW'(u_ff[0]); op_b = MW'(vsel[1]); end
                  5'd8: begin op_a = MW'(u_ff[1]); op_b = MW'(vsel[0]); end
                  5'd9: begin op_a = d_ff; op_b = UNIT_ONE - MW'(cos_q); end
                  5'd10: begin op_a = MW'(vsel[0]); op_b = MW'(cos_q); end
                  5'd11: begin op_a = MW'(vsel[1]); op_b = MW'(cos_q); end
                  5'd12: begin op_a = MW'(vsel[2]); op_b = MW'(cos_q); end
                  5'd13: begin op_a = w_ff[0]; op_b = MW'(sin_q); end
                  5'd14: begin op_a = w_ff[1]; op_b = MW'(sin_q); end
                  5'd15: begin op_a = w_ff[2]; op_b = MW'(sin_q); end
                  5'd16: begin op_a = MW'(u_ff[0]); op_b = t_ff; end
                  5'd17: begin op_a = MW'(u_ff[1]); op_b = t_ff; end
                  5'd18: begin op_a = MW'(u_ff[2]); op_b = t_ff; end
                  default: begin op_a = '0; op_b = '0; end
               endcase
               rv = rnd_f(pa);
               if (cnt_ff != 5'd0) begin
                  case (j)
                     5'd0: acc_in = pa;
                     5'd1: acc_in = acc_ff + pa;
                     5'd2: d_in = MW'(rnd_f(acc_ff + pa));
                     5'd3, 5'd5, 5'd7: acc_in = pa;
                     5'd4: w_in[0] = MW'(rnd_f(acc_ff - pa));
                     5'd6: w_in[1] = MW'(rnd_f(acc_ff - pa));
                     5'd8: w_in[2] = MW'(rnd_f(acc_ff - pa));
                     5'd9: t_in = MW'(rv);
                     5'd10: o_in[0] = rv;
                     5'd11: o_in[1] = rv;
                     5'd12: o_in[2] = rv;
                     5'd13, 5'd16: o_in[0] = o_ff[0] + rv;
                     5'd14, 5'd17: o_in[1] = o_ff[1] + rv;
                     5'd15, 5'd18: o_in[2] = o_ff[2] + rv;
                     default: acc_in = acc_ff;
                  endcase
               end
               cnt_in = cnt_ff + 5'd1;
               if (cnt_ff == 5'd20) begin
                  cnt_in = '0;
                  if (pass_ff) up_in = sat_o;
                  else eye_in = sat_o;
                  if (cmd_ff == CMD_UP && !pass_ff) begin
                     pass_in = 1'b1;
                  end else begin
                     state_in = ST_DONE;
                  end
               end
            end
         end

         ST_DONE: begin
            if (!rsp_tvalid_ff || rsp_tready) begin
               rsp_tvalid_in = 1'b1;
               rsp_tdata_in = OUT_W'({up_ff[2], up_ff[1], up_ff[0],
                                      eye_ff[2], eye_ff[1], eye_ff[0]});
               rsp_tuser_in = degen_ff;
               state_in = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rsp_tvalid_ff <= 1'b0;
         for (int i = 0; i < 3; i++) begin
            eye_ff[i] <= '0;
            up_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
         eye_ff <= eye_in;
         up_ff <= up_in;
      end
      cnt_ff <= cnt_in;
      cmd_ff <= cmd_in;
      pass_ff <= pass_in;
      degen_ff <= degen_in;
      ax_ff <= ax_in;
      m_ff <= m_in;
      sum_ff <= sum_in;
      u_ff <= u_in;
      acc_ff <= acc_in;
      d_ff <= d_in;
      t_ff <= t_in;
      w_ff <= w_in;
      o_ff <= o_in;
      rsp_tdata_ff <= rsp_tdata_in;
      rsp_tuser_ff <= rsp_tuser_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata = rsp_tdata_ff;
   assign rsp_tuser = rsp_tuser_ff;

endmodule

[src/ocr_checker.sv]
// Port-level checks for orbit_camera_rotate_core, bound to the top level.
// Depends on ocr_pkg for the command width.
module ocr_checker #(
   parameter int IN_W = 160,
   parameter int OUT_W = 144
) (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_tvalid,
   input logic                      req_tready,
   input logic [IN_W-1:0]           req_tdata,
   input logic [ocr_pkg::CMD_W-1:0] req_tuser,
   input logic                      rsp_tvalid,
   input logic                      rsp_tready,
   input logic [OUT_W-1:0]          rsp_tdata,
   input logic                      rsp_tuser
);
   import ocr_pkg::*;

   logic req_word;
   assign req_word = req_tvalid && req_tready && (req_tuser <= CMD_UP || IN_W > 0);

   // one word at a time: busy right after an accept
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_word |=> !req_tready)
      else $error("ocr: ready stayed high after accepting a word");

   // reset empties the output register
   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("ocr: result valid after reset");

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
                                    && $stable(rsp_tuser))
      else $error("ocr: stalled result changed");

   // no result appears in the cycle right after an accept
   a_min_latency: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> !$past(req_word))
      else $error("ocr: result too soon after accept");

endmodule

bind orbit_camera_rotate_core ocr_checker #(.IN_W(IN_W), .OUT_W(OUT_W)) u_ocr_checker (.*);

[tb/sv/tb_orbit_camera_rotate_core.sv]
// Testbench for orbit_camera_rotate_core: random and directed camera commands,
// each result checked against a bit-exact predictor of the rotation. Uses ocr_pkg.
`timescale 1ns / 100ps

module tb_orbit_camera_rotate_core;
   import ocr_pkg::*;

   localparam int CW = 24;
   localparam int IN_W = ((ANGLE_W + 6 * CW + 7) / 8) * 8;
   localparam int OUT_W = ((6 * CW + 7) / 8) * 8;
   localparam int ITEM_COUNT = 2000;
   localparam int CYCLE_LIMIT = 3000000;
   localparam int TAIL_CYCLES = 300;
   localparam longint ONE_Q28 = 64'sd1 << UNIT_SHIFT;
   localparam longint MAX_I64 = 64'sh7fffffffffffffff;
   localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;

   typedef longint vec3_type [3];

   typedef struct {
      logic [CMD_W-1:0]          cmd;
      logic signed [ANGLE_W-1:0] angle;
      logic signed [CW-1:0]      ld [6];
   } cam_cmd_type;

   typedef struct {
      logic [CW-1:0] vals [6];
      logic          degenerate;
   } cam_pose_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [IN_W-1:0] req_tdata = '0;
   logic [CMD_W-1:0] req_tuser = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [OUT_W-1:0] rsp_tdata;
   logic rsp_tuser;

   cam_cmd_type  cmd_queue [$];
   cam_pose_type pose_queue [$];
   vec3_type     eye_st, up_st;
   int        mismatches = 0;
   int        words_in = 0;
   int        words_out = 0;
   int        cycles = 0;

   orbit_camera_rotate_core uut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------- predictor ----------------
   function automatic longint round_q28(longint v);
      return (v + (64'sd1 <<< (UNIT_SHIFT - 1))) >>> UNIT_SHIFT;
   endfunction

   function automatic longint clamp_q28(longint v);
      return v > ONE_Q28 ? ONE_Q28 : (v < -ONE_Q28 ? -ONE_Q28 : v);
   endfunction

   function automatic longint sat_to_coord(longint v);
      longint hi, lo;
      hi = (64'sd1 <<< (CW - 1)) - 1;
      lo = -(64'sd1 <<< (CW - 1));
      return v > hi ? hi : (v < lo ? lo : v);
   endfunction

   function automatic longint diff_sat(longint p, longint q);
      if (q < 0 && p > MAX_I64 + q) return MAX_I64;
      if (q > 0 && p < -MAX_I64 + q) return -MAX_I64;
      return p - q;
   endfunction

   function automatic longint atan_step(int i);
      longint tbl [CORDIC_STEPS] = '{2949120, 1740967, 919879, 466945, 234379,
         117304, 58666, 29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29};
      return tbl[i];
   endfunction

   task automatic sine_cosine(input longint a, output longint s, output longint c);
      bit flip;
      longint x, y, z, dx, dy;
      flip = 1'b0;
      x = CORDIC_GAIN;
      y = 0;
      if (a > HALF_TURN) a -= FULL_TURN;
      if (a < -HALF_TURN) a += FULL_TURN;
      if (a > QUARTER_TURN) begin
         a -= HALF_TURN; flip = 1'b1;
      end else if (a < -QUARTER_TURN) begin
         a += HALF_TURN; flip = 1'b1;
      end
      z = a * 1024;
      for (int i = 0; i < CORDIC_STEPS; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (z >= 0) begin
            x -= dx; y += dy; z -= atan_step(i);
         end else begin
            x += dx; y -= dy; z += atan_step(i);
         end
      end
      if (flip) begin
         x = -x; y = -y;
      end
      c = clamp_q28(x);
      s = clamp_q28(y);
   endtask

   function automatic longint unsigned int_sqrt(longint unsigned v);
      longint unsigned res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      for (int i = 0; i < ROOT_STEPS; i++) begin
         if (v >= res + bitv) begin
            v -= res + bitv;
            res = (res >> 1) + bitv;
         end else res >>= 1;
         bitv >>= 2;
      end
      return res;
   endfunction

   // unit axis in Q2.28; returns 0 for a zero axis
   task automatic unit_axis(input vec3_type a, output vec3_type u, output bit ok);
      longint unsigned m, mag, sum, r;
      longint b [3];
      int k;
      bit left;
      m = 0; sum = 0; k = 0; left = 0;
      u = '{0, 0, 0};
      for (int i = 0; i < 3; i++) begin
         mag = a[i] < 0 ? 64'd0 - longint'(a[i]) : a[i];
         if (mag > m) m = mag;
      end
      ok = (m != 0);
      if (ok) begin
         while (m < (64'd1 << 29)) begin
            m <<= 1; k++; left = 1;
         end
         while (m >= (64'd1 << 30)) begin
            m >>= 1; k++;
         end
         for (int i = 0; i < 3; i++) begin
            b[i] = left ? a[i] * (64'sd1 <<< k) : a[i] >>> k;
            sum += b[i] * b[i];
         end
         r = int_sqrt(sum);
         if (r == 0) r = 1;
         for (int i = 0; i < 3; i++)
            u[i] = clamp_q28((b[i] * ONE_Q28) / longint'(r));
      end
   endtask

   function automatic vec3_type rodrigues(vec3_type u, longint s, longint c, vec3_type v);
      longint d, t;
      vec3_type w, o;
      d = round_q28(u[0] * v[0] + u[1] * v[1] + u[2] * v[2]);
      t = round_q28(d * (ONE_Q28 - c));
      w[0] = round_q28(u[1] * v[2] - u[2] * v[1]);
      w[1] = round_q28(u[2] * v[0] - u[0] * v[2]);
      w[2] = round_q28(u[0] * v[1] - u[1] * v[0]);
      for (int i = 0; i < 3; i++)
         o[i] = sat_to_coord(round_q28(v[i] * c) + round_q28(w[i] * s) + round_q28(u[i] * t));
      return o;
   endfunction

   task automatic apply_command(input cam_cmd_type it);
      cam_pose_type p;
      vec3_type u, ax;
      longint s, c, ang;
      bit ok;
      p.degenerate = 1'b0;
      ang = it.angle;
      if (it.cmd == CMD_LOAD) begin
         for (int i = 0; i < 3; i++) begin
            eye_st[i] = it.ld[i];
            up_st[i] = it.ld[3 + i];
         end
      end else if (it.cmd == CMD_LEFT) begin
         unit_axis(up_st, u, ok);
         if (ok) begin
            sine_cosine(ang, s, c);
            eye_st = rodrigues(u, s, c, eye_st);
         end else p.degenerate = 1'b1;
      end else if (it.cmd == CMD_UP) begin
         ax[0] = diff_sat(up_st[1] * eye_st[2], up_st[2] * eye_st[1]);
         ax[1] = diff_sat(up_st[2] * eye_st[0], up_st[0] * eye_st[2]);
         ax[2] = diff_sat(up_st[0] * eye_st[1], up_st[1] * eye_st[0]);
         unit_axis(ax, u, ok);
         if (ok) begin
            sine_cosine(-ang, s, c);
            eye_st = rodrigues(u, s, c, eye_st);
            up_st = rodrigues(u, s, c, up_st);
         end else p.degenerate = 1'b1;
      end
      for (int i = 0; i < 3; i++) begin
         p.vals[i] = eye_st[i][CW-1:0];
         p.vals[3 + i] = up_st[i][CW-1:0];
      end
      pose_queue.push_back(p);
   endtask

   // ---------------- stimulus ----------------
   function automatic logic signed [CW-1:0] rand_coord();
      int sel;
      sel = $urandom_range(0, 9);
      if (sel < 7) return CW'($signed($urandom_range(0, 2 ** 19)) - 2 ** 18);
      if (sel < 9) return CW'($signed($urandom_range(0, 2 ** 23)) - 2 ** 22);
      return CW'($urandom);
   endfunction

   task automatic add_cmd(logic [CMD_W-1:0] cmd, logic signed [ANGLE_W-1:0] angle,
                          logic signed [CW-1:0] ex, ey, ez, ux, uy, uz);
      cam_cmd_type it;
      it.cmd = cmd;
      it.angle = angle;
      it.ld = '{ex, ey, ez, ux, uy, uz};
      cmd_queue.push_back(it);
   endtask

   task automatic add_load_random();
      add_cmd(CMD_LOAD, ANGLE_W'($urandom), rand_coord(), rand_coord(), rand_coord(),
              rand_coord(), rand_coord(), rand_coord());
   endtask

   function automatic logic signed [ANGLE_W-1:0] rand_angle();
      if ($urandom_range(0, 19) == 0) return ANGLE_W'($urandom);
      return ANGLE_W'($signed($urandom_range(0, 2 * HALF_TURN)) - HALF_TURN);
   endfunction

   initial begin
      logic signed [CW-1:0] mx, mn;
      int n;
      mx = 24'sh7fffff;
      mn = 24'sh800000;
      // directed: zero state, degenerate axes, unused code, extreme values and angles
      add_cmd(CMD_LEFT, 15'sd100, 0, 0, 0, 0, 0, 0);
      add_cmd(CMD_UP, 15'sd100, 0, 0, 0, 0, 0, 0);
      add_cmd(CMD_SPARE, 15'sd0, mx, mx, mx, mx, mx, mx);
      add_cmd(CMD_LOAD, 15'sd0, 24'sd262144, 0, 0, 0, 24'sd65536, 0);
      add_cmd(CMD_LEFT, 15'sd0, 0, 0, 0, 0, 0, 0);
      add_cmd(CMD_LEFT, 15'sd5760, 0, 0, 0, 0, 0, 0);
      add_cmd(CMD_LEFT, 15'sd5761, 0, 0, 0, 0, 0, 0);
      add_cmd(CMD_LEFT, -15'sd5761, 0, 0, 0, 0, 0, 0);
      add_cmd(CMD_UP, 15'sd11520, 0, 0, 0, 0, 0, 0);
      add_cmd(CMD_UP, -15'sd11520, 0, 0, 0, 0, 0, 0);
      add_cmd(CMD_UP, 15'sh3fff, 0, 0, 0, 0, 0, 0);
      add_cmd(CMD_LEFT, 15'sh4000, 0, 0, 0, 0, 0, 0);
      add_cmd(CMD_SPARE, 15'sh4000, 0, 0, 0, 0, 0, 0);
      add_cmd(CMD_LOAD, 15'sd0, 24'sd65536, 24'sd65536, 0, 24'sd131072, 24'sd131072, 0);
      add_cmd(CMD_UP, 15'sd640, 0, 0, 0, 0, 0, 0);
      add_cmd(CMD_LOAD, 15'sh3fff, mx, mx, mx, mx, mn, mx);
      add_cmd(CMD_LEFT, 15'sd2000, 0, 0, 0, 0, 0, 0);
      add_cmd(CMD_UP, -15'sd3000, 0, 0, 0, 0, 0, 0);
      add_cmd(CMD_LOAD, 15'sh4000, mn, mn, mn, mn, mx, mn);
      add_cmd(CMD_UP, 15'sd7000, 0, 0, 0, 0, 0, 0);
      add_cmd(CMD_LOAD, 15'sd0, 1, -1, 0, 0, 0, 1);
      add_cmd(CMD_LEFT, 15'sd1234, 0, 0, 0, 0, 0, 0);
      add_cmd(CMD_UP, 15'sd1234, 0, 0, 0, 0, 0, 0);
      // random: mostly a load followed by a run of orbits, some noise
      while (cmd_queue.size() < ITEM_COUNT) begin
         add_load_random();
         n = $urandom_range(1, 8);
         for (int i = 0; i < n; i++)
            if ($urandom_range(0, 15) == 0)
               add_cmd(CMD_W'($urandom), rand_angle(), rand_coord(), rand_coord(),
                       rand_coord(), rand_coord(), rand_coord(), rand_coord());
            else
               add_cmd(CMD_W'($urandom_range(1, 2)), rand_angle(), CW'($urandom),
                       CW'($urandom), CW'($urandom), CW'($urandom), CW'($urandom),
                       CW'($urandom));
      end
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      wait (cmd_queue.size() == 0 && !req_tvalid);
      wait (pose_queue.size() == 0);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatches == 0)
         $display("tb_orbit_camera_rotate_core passed");
      else
         $display("tb_orbit_camera_rotate_core failed");
      $finish;
   end

   // ---------------- driver ----------------
   int  send_gap = 0;
   bit  drain_hold = 0;
   bit  drain_done = 0;

   always @(posedge clock) begin
      logic offer;
      cam_cmd_type it;
      if (!reset) begin
         offer = req_tvalid;
         if (req_tvalid && req_tready) begin
            apply_command(cmd_queue.pop_front());
            words_in++;
            offer = 1'b0;
            send_gap = $urandom_range(0, 10);
            if (words_in % 400 < 40) send_gap = 0;
            if (words_in == 1200 && !drain_done) begin
               drain_hold = 1; drain_done = 1;
            end
         end
         if (drain_hold && pose_queue.size() == 0) drain_hold = 0;
         if (!offer && !drain_hold) begin
            if (send_gap > 0) send_gap--;
            else if (cmd_queue.size() > 0) begin
               it = cmd_queue[0];
               req_tuser <= it.cmd;
               req_tdata <= {1'b0, it.ld[5], it.ld[4], it.ld[3], it.ld[2], it.ld[1],
                             it.ld[0], it.angle};
               offer = 1'b1;
            end
         end
         req_tvalid <= offer;
      end
   end

   // ---------------- monitor ----------------
   int  recv_stall = 0;
   bit  long_stall_done = 0;

   always @(posedge clock) begin
      logic take;
      cam_pose_type p;
      if (!reset) begin
         cycles++;
         take = rsp_tready;
         if (rsp_tvalid && rsp_tready) begin
            words_out++;
            if (pose_queue.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected result word %h", rsp_tdata);
            end else begin
               p = pose_queue.pop_front();
               for (int i = 0; i < 6; i++)
                  if (rsp_tdata[i*CW +: CW] !== p.vals[i]) begin
                     mismatches++;
                     if (mismatches <= 10)
                        $display("word %0d coord %0d: expected %h got %h",
                                 words_out, i, p.vals[i], rsp_tdata[i*CW +: CW]);
                  end
               if (rsp_tuser !== p.degenerate) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("word %0d degenerate: expected %b got %b",
                              words_out, p.degenerate, rsp_tuser);
               end
            end
            take = 1'b0;
            recv_stall = $urandom_range(0, 10);
            if (words_out % 300 < 30) recv_stall = 0;
            // one long hold-off while the sender keeps offering
            if (words_out == 600 && !long_stall_done) begin
               recv_stall = 3000; long_stall_done = 1;
            end
         end
         if (!take) begin
            if (recv_stall > 0) recv_stall--;
            else take = 1'b1;
         end
         rsp_tready <= take;
         if (cycles >= CYCLE_LIMIT) begin
            $display("tb_orbit_camera_rotate_core failed");
            $finish;
         end
      end
   end

endmodule
